/* src/tpft_pkg.sv */
// Package: types, constants and register codes for the tire pressure frame tracker.
package tpft_pkg;

    localparam int NUM_TIRES = 4;
    localparam int MAP_W = $clog2(NUM_TIRES);

    localparam int KIND_W = 2;
    localparam int FRAME_ID_W = 29;
    localparam int FRAME_LEN_W = 7;
    localparam int FRAME_DATA_W = 64;
    localparam int EVENT_ID_W = 8;
    localparam int EVENT_ARG_W = 8;
    localparam int PRESSURE_W = 8;
    localparam int ELAPSED_W = 16;
    localparam int NIBBLE_W = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 29;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_FRAME_ID = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_EVENT_ID = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_MS = 2'd2;

    localparam logic [FRAME_ID_W-1:0] MATCH_FRAME_ID_RESET = 29'h385;
    localparam logic [EVENT_ID_W-1:0] SWAP_EVENT_ID_RESET = 8'd0;
    localparam logic [ELAPSED_W-1:0] PERIOD_MS_RESET = 16'd1000;

    localparam logic [FRAME_LEN_W-1:0] PRESSURE_FRAME_LEN = 7'd8;
    localparam int VALID_BYTE = 7;
    localparam int FIRST_PRESSURE_BYTE = 2;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_FRAME = 2'd0,
        KIND_EVENT = 2'd1,
        KIND_POLL  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [FRAME_ID_W-1:0]   frame_id;
        logic [FRAME_LEN_W-1:0]  frame_len;
        logic [FRAME_DATA_W-1:0] frame_data;
        logic [EVENT_ID_W-1:0]   event_id;
        logic [EVENT_ARG_W-1:0]  event_arg;
    } item_t;

    typedef struct packed {
        logic [FRAME_ID_W-1:0] match_frame_id;
        logic [EVENT_ID_W-1:0] swap_event_id;
        logic [ELAPSED_W-1:0]  period_ms;
    } cfg_t;

    typedef logic [NUM_TIRES-1:0][PRESSURE_W-1:0] pressures_t;

    typedef struct packed {
        logic       valid;
        pressures_t pressure;
    } emit_t;

endpackage

/* src/tpft_if.sv */
// Channel interfaces: input item and result item, valid/ready handshake.
interface tpft_item_if import tpft_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [FRAME_ID_W-1:0]   frame_id;
    logic [FRAME_LEN_W-1:0]  frame_len;
    logic [FRAME_DATA_W-1:0] frame_data;
    logic [EVENT_ID_W-1:0]   event_id;
    logic [EVENT_ARG_W-1:0]  event_arg;

    modport source (
        output valid, kind, frame_id, frame_len, frame_data, event_id, event_arg,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_id, frame_len, frame_data, event_id, event_arg,
        output ready
    );
endinterface

interface tpft_result_if import tpft_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PRESSURE_W-1:0] pressure_0;
    logic [PRESSURE_W-1:0] pressure_1;
    logic [PRESSURE_W-1:0] pressure_2;
    logic [PRESSURE_W-1:0] pressure_3;

    modport source (
        output valid, pressure_0, pressure_1, pressure_2, pressure_3,
        input  ready
    );
    modport sink (
        input  valid, pressure_0, pressure_1, pressure_2, pressure_3,
        output ready
    );
endinterface

/* src/tire_pressure_frame_tracker_core.sv */
// Top level of the tire pressure frame tracker.
//
//  port      | role         | content
//  ----------+--------------+---------------------------------------------
//  item      | sink         | frame, swap event, poll or ms tick
//  result    | source       | four slot pressures, on an emitting poll
//  cfg_*     | write only   | match_frame_id, swap_event_id, period_ms
//
// One transaction per cycle while no poll stalls; each goes input register ->
// state update -> result register, from which an emitting poll's result is offered.
// Only a poll stalls, and only while the result register is still held.
// Reset (rst_n, async low) restores the map to 0..3, clears pressures,
// flag and counter, and loads the register reset values.
module tire_pressure_frame_tracker_core import tpft_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    tpft_item_if.sink              item,
    tpft_result_if.source          result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    logic  held_valid;
    item_t held_item;
    logic  take;
    logic  out_free;
    emit_t emit;

    tpft_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpft_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tpft_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .held_valid (held_valid),
        .held_item  (held_item),
        .out_free   (out_free),
        .take       (take),
        .emit       (emit)
    );

    tpft_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .out_free (out_free),
        .result   (result)
    );

endmodule

/* src/tpft_cfg_regs.sv */
// Configuration registers written through the plain write port.
module tpft_cfg_regs import tpft_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATCH_FRAME_ID: cfg_next.match_frame_id = cfg_data[FRAME_ID_W-1:0];
                CFG_SWAP_EVENT_ID:  cfg_next.swap_event_id = cfg_data[EVENT_ID_W-1:0];
                CFG_PERIOD_MS:      cfg_next.period_ms = cfg_data[ELAPSED_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_frame_id <= MATCH_FRAME_ID_RESET;
            cfg_reg.swap_event_id <= SWAP_EVENT_ID_RESET;
            cfg_reg.period_ms <= PERIOD_MS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/tpft_in_stage.sv */
// Input register: holds one accepted transaction until the tracker takes it.
module tpft_in_stage import tpft_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tpft_item_if.sink   item,
    input  logic        take,
    output logic        held_valid,
    output item_t       held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign item.ready = !valid_reg || take;
    assign load = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.kind <= item.kind;
            item_reg.frame_id <= item.frame_id;
            item_reg.frame_len <= item.frame_len;
            item_reg.frame_data <= item.frame_data;
            item_reg.event_id <= item.event_id;
            item_reg.event_arg <= item.event_arg;
        end
    end

    assign held_valid = valid_reg;
    assign held_item = item_reg;

endmodule

/* src/tpft_tracker.sv */
// Tracker state: slot map, stored pressures, change flag, elapsed counter.
module tpft_tracker import tpft_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  held_valid,
    input  item_t held_item,
    input  logic  out_free,
    output logic  take,
    output emit_t emit
);

    logic [NUM_TIRES-1:0][MAP_W-1:0] map_reg;
    logic [NUM_TIRES-1:0][MAP_W-1:0] map_next;
    pressures_t                      pressure_reg;
    pressures_t                      pressure_next;
    logic                            changed_reg;
    logic                            changed_next;
    logic [ELAPSED_W-1:0]            elapsed_reg;
    logic [ELAPSED_W-1:0]            elapsed_next;

    pressures_t                      sensor_byte;
    logic [NUM_TIRES-1:0]            sensor_ok;
    pressures_t                      frame_value;
    logic                            frame_hit;
    logic                            frame_diff;
    logic [NIBBLE_W-1:0]             slot_i;
    logic [NIBBLE_W-1:0]             slot_j;
    logic                            swap_hit;
    logic                            poll_emit;

    // Sensor t: byte 2+t, valid bit 7-t of byte 7
    always_comb
    begin
        for (int t = 0; t < NUM_TIRES; t++)
        begin
            sensor_byte[t] = held_item.frame_data[PRESSURE_W*(FIRST_PRESSURE_BYTE+t) +: PRESSURE_W];
            sensor_ok[t] = held_item.frame_data[PRESSURE_W*VALID_BYTE + (PRESSURE_W-1) - t];
        end
    end

    always_comb
    begin
        frame_diff = 1'b0;
        for (int s = 0; s < NUM_TIRES; s++)
        begin
            frame_value[s] = sensor_ok[map_reg[s]] ? sensor_byte[map_reg[s]] : '0;
            if (frame_value[s] != pressure_reg[s])
            begin
                frame_diff = 1'b1;
            end
        end
    end

    assign frame_hit = (held_item.frame_id == cfg.match_frame_id)
                    && (held_item.frame_len == PRESSURE_FRAME_LEN);

    assign slot_i = held_item.event_arg[NIBBLE_W-1:0];
    assign slot_j = held_item.event_arg[EVENT_ARG_W-1:NIBBLE_W];
    assign swap_hit = (held_item.event_id == cfg.swap_event_id)
                   && (slot_i[NIBBLE_W-1:MAP_W] == '0)
                   && (slot_j[NIBBLE_W-1:MAP_W] == '0)
                   && (slot_i != slot_j);

    assign poll_emit = changed_reg || (elapsed_reg >= cfg.period_ms);

    // A poll waits only while the result register is still occupied
    assign take = held_valid && (kind_t'(held_item.kind) != KIND_POLL || out_free);

    always_comb
    begin
        map_next = map_reg;
        pressure_next = pressure_reg;
        changed_next = changed_reg;
        elapsed_next = elapsed_reg;
        emit.valid = 1'b0;
        emit.pressure = pressure_reg;
        if (take)
        begin
            case (kind_t'(held_item.kind))
                KIND_FRAME:
                begin
                    if (frame_hit)
                    begin
                        pressure_next = frame_value;
                        changed_next = changed_reg || frame_diff;
                    end
                end
                KIND_EVENT:
                begin
                    if (swap_hit)
                    begin
                        map_next[slot_i[MAP_W-1:0]] = map_reg[slot_j[MAP_W-1:0]];
                        map_next[slot_j[MAP_W-1:0]] = map_reg[slot_i[MAP_W-1:0]];
                        pressure_next[slot_i[MAP_W-1:0]] = pressure_reg[slot_j[MAP_W-1:0]];
                        pressure_next[slot_j[MAP_W-1:0]] = pressure_reg[slot_i[MAP_W-1:0]];
                        changed_next = 1'b1;
                    end
                end
                KIND_POLL:
                begin
                    if (poll_emit)
                    begin
                        emit.valid = 1'b1;
                        changed_next = 1'b0;
                        elapsed_next = '0;
                    end
                end
                KIND_TICK:
                begin
                    if (elapsed_reg != ELAPSED_MAX)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                default:
                begin
                    changed_next = changed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_TIRES; s++)
            begin
                map_reg[s] <= MAP_W'(s);
            end
            pressure_reg <= '0;
            changed_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
            pressure_reg <= pressure_next;
            changed_reg <= changed_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

/* src/tpft_out_stage.sv */
// Result register: holds one emitted transaction until the sink takes it.
module tpft_out_stage import tpft_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  emit_t        emit,
    output logic         out_free,
    tpft_result_if.source result
);

    logic       valid_reg;
    logic       valid_next;
    pressures_t pressure_reg;

    assign out_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit.valid)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            pressure_reg <= emit.pressure;
        end
    end

    assign result.valid = valid_reg;
    assign result.pressure_0 = pressure_reg[0];
    assign result.pressure_1 = pressure_reg[1];
    assign result.pressure_2 = pressure_reg[2];
    assign result.pressure_3 = pressure_reg[3];

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the tire pressure frame tracker core, with its own tracker copy.
module tb;
    import tpft_pkg::*;

    // Index beyond the three registers; a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_PERCENT = 27;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STEADY_FROM = 500;
    localparam int STEADY_TO = 800;
    localparam int LONG_PERIOD_TICKS = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tpft_item_if   item_ch ();
    tpft_result_if result_ch ();

    tire_pressure_frame_tracker_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tracker copy
    logic [MAP_W-1:0]      sensor_of [NUM_TIRES];
    logic [PRESSURE_W-1:0] held_pressure [NUM_TIRES];
    logic                  pressure_dirty;
    logic [ELAPSED_W-1:0]  ms_elapsed;
    cfg_t                  live_cfg;
    pressures_t            pending_reports [$];

    // Stimulus side
    item_t                   queued_items [$];
    item_t                   next_item;
    item_t                   item_seen;
    pressures_t              report_seen;
    pressures_t              report_want;
    int unsigned             items_sent;
    int unsigned             items_taken;
    int unsigned             quiet_cycles;
    int unsigned             mismatches;
    logic [FRAME_ID_W-1:0]   stim_frame_id;
    logic [EVENT_ID_W-1:0]   stim_swap_id;
    logic [FRAME_DATA_W-1:0] last_payload;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        item_ch.valid      = 1'b0;
        item_ch.kind       = '0;
        item_ch.frame_id   = '0;
        item_ch.frame_len  = '0;
        item_ch.frame_data = '0;
        item_ch.event_id   = '0;
        item_ch.event_arg  = '0;
        result_ch.ready    = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
    end

    function automatic logic [PRESSURE_W-1:0] sensor_reading(
        input logic [FRAME_DATA_W-1:0] payload,
        input logic [MAP_W-1:0]        sensor
    );
        logic [7:0] valid_bits;
        valid_bits = payload[8*VALID_BYTE +: 8];
        if (valid_bits[7 - sensor])
            return payload[8*(FIRST_PRESSURE_BYTE + sensor) +: 8];
        return '0;
    endfunction

    task automatic clear_tracker();
        for (int s = 0; s < NUM_TIRES; s++)
        begin
            sensor_of[s]     = MAP_W'(s);
            held_pressure[s] = '0;
        end
        pressure_dirty          = 1'b0;
        ms_elapsed              = '0;
        live_cfg.match_frame_id = MATCH_FRAME_ID_RESET;
        live_cfg.swap_event_id  = SWAP_EVENT_ID_RESET;
        live_cfg.period_ms      = PERIOD_MS_RESET;
    endtask

    task automatic track_item(input item_t it);
        logic [PRESSURE_W-1:0] reading;
        logic [NIBBLE_W-1:0]   slot_a;
        logic [NIBBLE_W-1:0]   slot_b;
        logic [MAP_W-1:0]      map_tmp;
        logic [PRESSURE_W-1:0] val_tmp;
        pressures_t            report;
        case (kind_t'(it.kind))
            KIND_FRAME:
            begin
                if (it.frame_id == live_cfg.match_frame_id && it.frame_len == PRESSURE_FRAME_LEN)
                begin
                    for (int s = 0; s < NUM_TIRES; s++)
                    begin
                        reading = sensor_reading(it.frame_data, sensor_of[s]);
                        if (held_pressure[s] != reading)
                        begin
                            held_pressure[s] = reading;
                            pressure_dirty   = 1'b1;
                        end
                    end
                end
            end
            KIND_EVENT:
            begin
                slot_a = it.event_arg[NIBBLE_W-1:0];
                slot_b = it.event_arg[2*NIBBLE_W-1:NIBBLE_W];
                if (it.event_id == live_cfg.swap_event_id && slot_a < NUM_TIRES
                    && slot_b < NUM_TIRES && slot_a != slot_b)
                begin
                    map_tmp                = sensor_of[slot_a[MAP_W-1:0]];
                    sensor_of[slot_a[MAP_W-1:0]] = sensor_of[slot_b[MAP_W-1:0]];
                    sensor_of[slot_b[MAP_W-1:0]] = map_tmp;
                    val_tmp                = held_pressure[slot_a[MAP_W-1:0]];
                    held_pressure[slot_a[MAP_W-1:0]] = held_pressure[slot_b[MAP_W-1:0]];
                    held_pressure[slot_b[MAP_W-1:0]] = val_tmp;
                    pressure_dirty         = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if (ms_elapsed != ELAPSED_MAX)
                    ms_elapsed++;
            end
            default:
            begin
                if (pressure_dirty || ms_elapsed >= live_cfg.period_ms)
                begin
                    ms_elapsed     = '0;
                    pressure_dirty = 1'b0;
                    for (int s = 0; s < NUM_TIRES; s++)
                        report[s] = held_pressure[s];
                    pending_reports.push_back(report);
                end
            end
        endcase
    endtask

    // Unused fields carry random values on every kind
    function automatic item_t any_item(input kind_t k);
        item_t it;
        it.kind       = k;
        it.frame_id   = FRAME_ID_W'($urandom);
        it.frame_len  = FRAME_LEN_W'($urandom_range(64));
        it.frame_data = {$urandom, $urandom};
        it.event_id   = EVENT_ID_W'($urandom);
        it.event_arg  = EVENT_ARG_W'($urandom);
        return it;
    endfunction

    function automatic item_t frame_item(
        input logic [FRAME_ID_W-1:0]   id,
        input logic [FRAME_LEN_W-1:0]  len,
        input logic [FRAME_DATA_W-1:0] payload
    );
        item_t it;
        it            = any_item(KIND_FRAME);
        it.frame_id   = id;
        it.frame_len  = len;
        it.frame_data = payload;
        return it;
    endfunction

    function automatic item_t event_item(
        input logic [EVENT_ID_W-1:0]  id,
        input logic [EVENT_ARG_W-1:0] arg
    );
        item_t it;
        it           = any_item(KIND_EVENT);
        it.event_id  = id;
        it.event_arg = arg;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t                   it;
        int                      pick;
        int                      shape;
        logic [FRAME_ID_W-1:0]   id;
        logic [FRAME_LEN_W-1:0]  len;
        logic [FRAME_DATA_W-1:0] payload;
        logic [EVENT_ARG_W-1:0]  arg;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            shape = $urandom_range(99);
            id    = stim_frame_id;
            len   = PRESSURE_FRAME_LEN;
            if (shape >= 75 && shape < 85)
                id = FRAME_ID_W'($urandom);
            else if (shape >= 85 && shape < 95)
                len = FRAME_LEN_W'($urandom_range(64));
            else if (shape >= 95)
            begin
                id  = FRAME_ID_W'($urandom);
                len = FRAME_LEN_W'($urandom_range(64));
            end
            // a repeated payload lets the changed flag stay clear
            if ($urandom_range(99) < 40)
                payload = last_payload;
            else
            begin
                payload      = {$urandom, $urandom};
                last_payload = payload;
            end
            it = frame_item(id, len, payload);
        end
        else if (pick < 50)
        begin
            if ($urandom_range(99) < 85)
                arg = {NIBBLE_W'($urandom_range(NUM_TIRES - 1)),
                       NIBBLE_W'($urandom_range(NUM_TIRES - 1))};
            else
                arg = EVENT_ARG_W'($urandom);
            if ($urandom_range(99) < 70)
                it = event_item(stim_swap_id, arg);
            else
                it = event_item(EVENT_ID_W'($urandom), arg);
        end
        else if (pick < 75)
            it = any_item(KIND_TICK);
        else
            it = any_item(KIND_POLL);
        return it;
    endfunction

    function automatic bit idle_now();
        if (items_taken >= STEADY_FROM && items_taken < STEADY_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // Driver: holds an offered transaction until taken, then offers the next or idles
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(item_ch.valid && items_sent != items_taken))
            begin
                if (queued_items.size() != 0 && !idle_now())
                begin
                    next_item          = queued_items.pop_front();
                    item_ch.kind       <= next_item.kind;
                    item_ch.frame_id   <= next_item.frame_id;
                    item_ch.frame_len  <= next_item.frame_len;
                    item_ch.frame_data <= next_item.frame_data;
                    item_ch.event_id   <= next_item.event_id;
                    item_ch.event_arg  <= next_item.event_arg;
                    item_ch.valid      <= 1'b1;
                    items_sent++;
                end
                else
                    item_ch.valid <= 1'b0;
            end
            result_ch.ready <= !idle_now();
        end
    end

    // Monitor: register writes, both channels and the watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_tracker();
            quiet_cycles = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MATCH_FRAME_ID: live_cfg.match_frame_id = cfg_data[FRAME_ID_W-1:0];
                    CFG_SWAP_EVENT_ID:  live_cfg.swap_event_id = cfg_data[EVENT_ID_W-1:0];
                    CFG_PERIOD_MS:      live_cfg.period_ms = cfg_data[ELAPSED_W-1:0];
                    default:            ;
                endcase
            end
            quiet_cycles++;
            // result first, so a poll taken on this edge cannot claim it
            if (result_ch.valid && result_ch.ready)
            begin
                quiet_cycles = 0;
                report_seen  = {result_ch.pressure_3, result_ch.pressure_2,
                                result_ch.pressure_1, result_ch.pressure_0};
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected result transaction: pressures %h", report_seen);
                    mismatches++;
                end
                else
                begin
                    report_want = pending_reports.pop_front();
                    for (int s = 0; s < NUM_TIRES; s++)
                    begin
                        if (report_seen[s] !== report_want[s])
                        begin
                            $error("pressure_%0d: expected %0d, got %0d",
                                   s, report_want[s], report_seen[s]);
                            mismatches++;
                        end
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                quiet_cycles = 0;
                item_seen    = {item_ch.kind, item_ch.frame_id, item_ch.frame_len,
                                item_ch.frame_data, item_ch.event_id, item_ch.event_arg};
                track_item(item_seen);
                items_taken++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0]  value
    );
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sampled at the falling edge, clear of the monitor's updates
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_items.size() != 0 || items_sent != items_taken
               || pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(
        input logic [FRAME_ID_W-1:0] frame_id,
        input logic [EVENT_ID_W-1:0] swap_id,
        input logic [ELAPSED_W-1:0]  period,
        input int                    count
    );
        write_reg(CFG_MATCH_FRAME_ID, CFG_DATA_W'(frame_id));
        write_reg(CFG_SWAP_EVENT_ID, CFG_DATA_W'(swap_id));
        write_reg(CFG_PERIOD_MS, CFG_DATA_W'(period));
        stim_frame_id = frame_id;
        stim_swap_id  = swap_id;
        repeat (count) queued_items.push_back(random_item());
        wait_drained();
    endtask

    initial
    begin
        items_sent    = 0;
        items_taken   = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        stim_frame_id = MATCH_FRAME_ID_RESET;
        stim_swap_id  = SWAP_EVENT_ID_RESET;
        last_payload  = '0;
        rst_n         = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, register reset values
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, PRESSURE_FRAME_LEN,
                                          64'hF000_4433_2211_0000));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(frame_item(FRAME_ID_W'(MATCH_FRAME_ID_RESET + 1),
                                          PRESSURE_FRAME_LEN, 64'hF000_9999_9999_0000));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, 7'd7, 64'hF000_9999_9999_0000));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, 7'd64, 64'hF000_9999_9999_0000));
        queued_items.push_back(frame_item('1, PRESSURE_FRAME_LEN, 64'hF000_9999_9999_0000));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, PRESSURE_FRAME_LEN, '1));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, PRESSURE_FRAME_LEN,
                                          64'hA000_5566_7788_0000));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(event_item(8'd5, 8'h10));
        queued_items.push_back(event_item(SWAP_EVENT_ID_RESET, 8'h22));
        queued_items.push_back(event_item(SWAP_EVENT_ID_RESET, 8'h4F));
        queued_items.push_back(event_item(SWAP_EVENT_ID_RESET, 8'hF0));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(event_item(SWAP_EVENT_ID_RESET, 8'h10));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(event_item(SWAP_EVENT_ID_RESET, 8'h32));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, PRESSURE_FRAME_LEN,
                                          64'hA000_5566_7788_0000));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, PRESSURE_FRAME_LEN,
                                          64'h5000_1234_5678_0000));
        queued_items.push_back(any_item(KIND_POLL));
        repeat (3) queued_items.push_back(any_item(KIND_TICK));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(frame_item(MATCH_FRAME_ID_RESET, PRESSURE_FRAME_LEN, '0));
        queued_items.push_back(any_item(KIND_POLL));
        wait_drained();

        // Random phases over a spread of register settings
        run_phase(FRAME_ID_W'($urandom), 8'hFF, 16'd1, 350);
        run_phase('0, EVENT_ID_W'($urandom), 16'd0, 350);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        run_phase('1, '0, 16'd3, 350);

        // Longest period: only the changed flag makes a poll emit
        write_reg(CFG_PERIOD_MS, CFG_DATA_W'(ELAPSED_MAX));
        queued_items.push_back(event_item(stim_swap_id, 8'h10));
        queued_items.push_back(any_item(KIND_POLL));
        repeat (LONG_PERIOD_TICKS) queued_items.push_back(any_item(KIND_TICK));
        queued_items.push_back(any_item(KIND_POLL));
        queued_items.push_back(any_item(KIND_POLL));
        wait_drained();

        run_phase(FRAME_ID_W'($urandom), EVENT_ID_W'($urandom),
                  ELAPSED_W'($urandom_range(2, 8)), 700);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
src/tpft_pkg.sv
src/tpft_if.sv
src/tpft_cfg_regs.sv
src/tpft_in_stage.sv
src/tpft_tracker.sv
src/tpft_out_stage.sv
src/tire_pressure_frame_tracker_core.sv
bench/tb.sv
